// ----- src/depq_pkg.sv -----
// Shared codes and types for the double-ended priority queue unit.
// No dependencies; used by depq_mem, depq_seq and the top level.
package depq_pkg;

  localparam int DEFAULT_CAPACITY = 256;
  localparam int DEFAULT_KEY_BITS = 32;

  localparam logic [2:0] MODE_LOAD  = 3'd0;
  localparam logic [2:0] MODE_BUILD = 3'd1;
  localparam logic [2:0] MODE_RMIN  = 3'd2;
  localparam logic [2:0] MODE_RMAX  = 3'd3;
  localparam logic [2:0] MODE_DMIN  = 3'd4;
  localparam logic [2:0] MODE_DMAX  = 3'd5;
  localparam logic [2:0] MODE_PEEK  = 3'd6;

  localparam logic [2:0] STAT_OK    = 3'd0;
  localparam logic [2:0] STAT_FULL  = 3'd1;
  localparam logic [2:0] STAT_EMPTY = 3'd2;
  localparam logic [2:0] STAT_NOTB  = 3'd3;
  localparam logic [2:0] STAT_BAD   = 3'd4;

  // write enables of one heap memory: whole entry, or link field only
  typedef struct packed {
    logic full;
    logic link;
  } mem_wr_t;

endpackage

// ----- src/depq_mem.sv -----
// One heap memory: key, tag and cross link per slot, one read and one write port.
// Depends on depq_pkg (mem_wr_t).
module depq_mem import depq_pkg::*; #(
  parameter int KEY_BITS = DEFAULT_KEY_BITS,
  parameter int IW       = 8
) (
  input  logic                clk,
  input  mem_wr_t             wr,
  input  logic [IW-1:0]       wr_addr,
  input  logic [KEY_BITS-1:0] wr_key,
  input  logic [7:0]          wr_tag,
  input  logic [IW-1:0]       wr_link,
  input  logic [IW-1:0]       rd_addr,
  output logic [KEY_BITS-1:0] rd_key,
  output logic [7:0]          rd_tag,
  output logic [IW-1:0]       rd_link
);

  localparam int DEPTH = 1 << IW;

  logic [KEY_BITS-1:0] keys  [DEPTH];
  logic [7:0]          tags  [DEPTH];
  logic [IW-1:0]       links [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.full) begin
      keys[wr_addr] <= wr_key;
      tags[wr_addr] <= wr_tag;
    end
    if (wr.full || wr.link) begin
      links[wr_addr] <= wr_link;
    end
    rd_key  <= keys[rd_addr];
    rd_tag  <= tags[rd_addr];
    rd_link <= links[rd_addr];
  end

endmodule

// ----- src/depq_seq.sv -----
// Sequencer: runs load, build, replace, delete and peek as read-modify-write
// steps on the two heap memories. Depends on depq_pkg.
module depq_seq import depq_pkg::*; #(
  parameter int CAPACITY = DEFAULT_CAPACITY,
  parameter int KEY_BITS = DEFAULT_KEY_BITS,
  parameter int IW       = 8,
  parameter int CW       = 9
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          mode,
  input  logic [31:0]         key,
  input  logic [7:0]          tag,
  output logic                done,
  output logic [31:0]         min_key,
  output logic [7:0]          min_tag,
  output logic [31:0]         max_key,
  output logic [7:0]          max_tag,
  output logic [CW-1:0]       count,
  output logic [2:0]          status,
  output mem_wr_t             m0_wr,
  output logic [IW-1:0]       m0_wr_addr,
  output logic [KEY_BITS-1:0] m0_wr_key,
  output logic [7:0]          m0_wr_tag,
  output logic [IW-1:0]       m0_wr_link,
  output mem_wr_t             m1_wr,
  output logic [IW-1:0]       m1_wr_addr,
  output logic [KEY_BITS-1:0] m1_wr_key,
  output logic [7:0]          m1_wr_tag,
  output logic [IW-1:0]       m1_wr_link,
  output logic [IW-1:0]       rd_addr,
  input  logic [KEY_BITS-1:0] m0_rd_key,
  input  logic [7:0]          m0_rd_tag,
  input  logic [IW-1:0]       m0_rd_link,
  input  logic [KEY_BITS-1:0] m1_rd_key,
  input  logic [7:0]          m1_rd_tag,
  input  logic [IW-1:0]       m1_rd_link
);

  localparam int XW = IW + 2;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_DISP = 5'd1;
  localparam logic [4:0] S_R1   = 5'd2;
  localparam logic [4:0] S_R2   = 5'd3;
  localparam logic [4:0] S_D1   = 5'd4;
  localparam logic [4:0] S_NEXT = 5'd5;
  localparam logic [4:0] S_SDA  = 5'd6;
  localparam logic [4:0] S_SDB  = 5'd7;
  localparam logic [4:0] S_SDC  = 5'd8;
  localparam logic [4:0] S_SDD  = 5'd9;
  localparam logic [4:0] S_SUA  = 5'd10;
  localparam logic [4:0] S_SUB  = 5'd11;
  localparam logic [4:0] S_SUC  = 5'd12;
  localparam logic [4:0] S_X1   = 5'd13;
  localparam logic [4:0] S_X2   = 5'd14;
  localparam logic [4:0] S_RM0  = 5'd15;
  localparam logic [4:0] S_RM1  = 5'd16;
  localparam logic [4:0] S_FIN  = 5'd17;
  localparam logic [4:0] S_OUT  = 5'd18;

  logic [4:0]          state;
  logic [2:0]          op;
  logic [KEY_BITS-1:0] ikey;
  logic [7:0]          itag;
  logic [CW-1:0]       cnt;
  logic                built;
  logic [2:0]          stat;
  logic [2:0]          st;
  logic                hs;        // heap being sifted; the other one gets link fixes
  logic                kind_up;
  logic [IW-1:0]       si, jb, pp, bidx;
  logic [CW-1:0]       nb;
  logic [KEY_BITS-1:0] ea_key, el_key, eb_key;
  logic [7:0]          ea_tag, el_tag, eb_tag;
  logic [IW-1:0]       ea_link, el_link, eb_link;

  logic                rsel, own;
  logic [KEY_BITS-1:0] rk;
  logic [7:0]          rt;
  logic [IW-1:0]       rl;
  logic [CW-1:0]       last;
  logic [XW-1:0]       lx, rx;
  logic [IW-1:0]       pidx;
  logic                lv, rv, pick_l, pick_r;
  logic [KEY_BITS-1:0] b1_key, kin;
  logic [7:0]          b1_tag;
  logic [63+KEY_BITS:0] kin_ext;
  logic [31+KEY_BITS:0] k0_ext, k1_ext;
  logic                show;

  // write port A: full write into heap hs; port B: heap ~hs
  logic                a_en, b_full, b_link;
  logic [IW-1:0]       a_addr, b_addr, a_link, b_lval;
  logic [KEY_BITS-1:0] a_key, b_key;
  logic [7:0]          a_tag, b_tag;

  function automatic logic ranks(input logic mx, input logic [KEY_BITS-1:0] ka,
                                 input logic [7:0] ta, input logic [KEY_BITS-1:0] kb,
                                 input logic [7:0] tb);
    if (ka != kb) return mx ? (ka > kb) : (ka < kb);
    return ta < tb;
  endfunction

  assign kin_ext = {64'b0, key};
  assign kin     = kin_ext[KEY_BITS-1:0];
  assign own     = (op == MODE_RMAX) || (op == MODE_DMAX);
  assign rsel    = (state == S_R2) ? ~hs : hs;
  assign rk      = rsel ? m1_rd_key  : m0_rd_key;
  assign rt      = rsel ? m1_rd_tag  : m0_rd_tag;
  assign rl      = rsel ? m1_rd_link : m0_rd_link;
  assign last    = CW'(cnt - CW'(1));
  assign lx      = {1'b0, si, 1'b1};
  assign rx      = XW'(lx + XW'(1));
  assign pidx    = IW'((si - IW'(1)) >> 1);
  assign lv      = lx < XW'(nb);
  assign rv      = rx < XW'(nb);
  assign pick_l  = lv && ranks(hs, el_key, el_tag, ea_key, ea_tag);
  assign b1_key  = pick_l ? el_key : ea_key;
  assign b1_tag  = pick_l ? el_tag : ea_tag;
  assign pick_r  = rv && ranks(hs, rk, rt, b1_key, b1_tag);

  assign busy    = state != S_IDLE;
  assign done    = state == S_OUT;
  assign show    = built && (cnt != '0);
  assign k0_ext  = {32'b0, m0_rd_key};
  assign k1_ext  = {32'b0, m1_rd_key};
  assign min_key = show ? k0_ext[31:0] : '0;
  assign min_tag = show ? m0_rd_tag : '0;
  assign max_key = show ? k1_ext[31:0] : '0;
  assign max_tag = show ? m1_rd_tag : '0;
  assign count   = cnt;
  assign status  = stat;

  always_comb begin
    a_en = 1'b0; b_full = 1'b0; b_link = 1'b0;
    a_addr = si; a_key = rk; a_tag = rt; a_link = rl;
    b_addr = si; b_key = rk; b_tag = rt; b_lval = si;
    rd_addr = '0;
    unique case (state)
      S_DISP: begin
        if (op == MODE_LOAD && cnt < CW'(CAPACITY)) begin
          a_en = 1'b1; b_full = 1'b1;
          a_addr = IW'(cnt); a_key = ikey; a_tag = itag; a_link = IW'(cnt);
          b_addr = IW'(cnt); b_key = ikey; b_tag = itag; b_lval = IW'(cnt);
        end
      end
      S_R1: begin
        a_en = 1'b1; a_addr = '0; a_key = ikey;
        rd_addr = rl;
      end
      S_R2: begin
        b_full = 1'b1; b_addr = pp; b_key = ikey; b_tag = rt; b_lval = rl;
      end
      S_SDA, S_SUA: rd_addr = si;
      S_SDB: rd_addr = lx[IW-1:0];
      S_SDC: rd_addr = rx[IW-1:0];
      S_SUB: rd_addr = pidx;
      S_RM0: rd_addr = IW'(last);
      S_RM1: begin
        a_en = 1'b1; b_link = 1'b1; b_addr = rl; b_lval = si;
      end
      S_X1: begin
        a_en = 1'b1; a_key = eb_key; a_tag = eb_tag; a_link = eb_link;
        b_link = 1'b1; b_addr = eb_link; b_lval = si;
      end
      S_X2: begin
        a_en = 1'b1; a_addr = jb; a_key = ea_key; a_tag = ea_tag; a_link = ea_link;
        b_link = 1'b1; b_addr = ea_link; b_lval = jb;
      end
      default: ;
    endcase
  end

  always_comb begin
    m0_wr.full = hs ? b_full : a_en;
    m0_wr.link = hs ? b_link : 1'b0;
    m0_wr_addr = hs ? b_addr : a_addr;
    m0_wr_key  = hs ? b_key  : a_key;
    m0_wr_tag  = hs ? b_tag  : a_tag;
    m0_wr_link = hs ? b_lval : a_link;
    m1_wr.full = hs ? a_en   : b_full;
    m1_wr.link = hs ? 1'b0   : b_link;
    m1_wr_addr = hs ? a_addr : b_addr;
    m1_wr_key  = hs ? a_key  : b_key;
    m1_wr_tag  = hs ? a_tag  : b_tag;
    m1_wr_link = hs ? a_link : b_lval;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      built <= 1'b0;
      stat  <= STAT_OK;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op <= mode; ikey <= kin; itag <= tag;
            state <= S_DISP;
          end
        end
        S_DISP: begin
          stat <= STAT_OK;
          st   <= '0;
          state <= S_FIN;
          if (op == MODE_LOAD) begin
            if (cnt >= CW'(CAPACITY)) begin
              stat <= STAT_FULL;
            end else begin
              cnt   <= CW'(cnt + CW'(1));
              built <= 1'b0;
            end
          end else if (op == MODE_BUILD) begin
            hs    <= 1'b0;
            bidx  <= IW'(cnt >> 1);
            state <= S_NEXT;
          end else if (op > MODE_PEEK) begin
            stat <= STAT_BAD;
          end else if (cnt == '0) begin
            stat <= STAT_EMPTY;
          end else if (!built) begin
            stat <= STAT_NOTB;
          end else if (op != MODE_PEEK) begin
            hs    <= own;
            state <= (op == MODE_RMIN || op == MODE_RMAX) ? S_R1 : S_D1;
          end
        end
        S_R1: begin
          pp    <= rl;
          state <= S_R2;
        end
        S_R2: state <= S_NEXT;
        S_D1: begin
          pp    <= rl;
          state <= S_NEXT;
        end
        S_NEXT: begin
          st <= 3'(st + 3'd1);
          case (op)
            MODE_BUILD: begin
              if (bidx == '0) begin
                if (!hs) begin
                  hs   <= 1'b1;
                  bidx <= IW'(cnt >> 1);
                end else begin
                  built <= 1'b1;
                  state <= S_FIN;
                end
              end else begin
                bidx  <= IW'(bidx - IW'(1));
                si    <= IW'(bidx - IW'(1));
                nb    <= cnt;
                state <= S_SDA;
              end
            end
            MODE_RMIN, MODE_RMAX: begin
              case (st)
                3'd0: begin si <= '0; nb <= cnt; state <= S_SDA; end
                3'd1: begin hs <= ~own; si <= pp; nb <= cnt; state <= S_SDA; end
                3'd2: begin hs <= ~own; si <= pp; state <= S_SUA; end
                default: state <= S_FIN;
              endcase
            end
            default: begin
              // delete: remove from own heap at root, then from other at pp
              case (st)
                3'd0: begin hs <= own; si <= '0; state <= S_RM0; end
                3'd1: begin hs <= own; si <= '0; nb <= last; state <= S_SDA; end
                3'd2: begin hs <= ~own; si <= pp; state <= S_RM0; end
                3'd3: begin hs <= ~own; si <= pp; nb <= last; state <= S_SDA; end
                3'd4: begin
                  hs <= ~own; si <= pp;
                  state <= (CW'(pp) < last) ? S_SUA : S_NEXT;
                end
                default: begin
                  cnt   <= last;
                  state <= S_FIN;
                end
              endcase
            end
          endcase
        end
        S_RM0: state <= (CW'(si) == last) ? S_NEXT : S_RM1;
        S_RM1: state <= S_NEXT;
        S_SDA: begin
          kind_up <= 1'b0;
          state   <= (XW'(si) >= XW'(nb)) ? S_NEXT : S_SDB;
        end
        S_SDB: begin
          ea_key <= rk; ea_tag <= rt; ea_link <= rl;
          state  <= S_SDC;
        end
        S_SDC: begin
          el_key <= rk; el_tag <= rt; el_link <= rl;
          state  <= S_SDD;
        end
        S_SDD: begin
          if (pick_r) begin
            eb_key <= rk; eb_tag <= rt; eb_link <= rl;
            jb <= rx[IW-1:0];
            state <= S_X1;
          end else if (pick_l) begin
            eb_key <= el_key; eb_tag <= el_tag; eb_link <= el_link;
            jb <= lx[IW-1:0];
            state <= S_X1;
          end else begin
            state <= S_NEXT;
          end
        end
        S_SUA: begin
          kind_up <= 1'b1;
          state   <= (si == '0) ? S_NEXT : S_SUB;
        end
        S_SUB: begin
          ea_key <= rk; ea_tag <= rt; ea_link <= rl;
          state  <= S_SUC;
        end
        S_SUC: begin
          if (ranks(hs, ea_key, ea_tag, rk, rt)) begin
            eb_key <= rk; eb_tag <= rt; eb_link <= rl;
            jb <= pidx;
            state <= S_X1;
          end else begin
            state <= S_NEXT;
          end
        end
        S_X1: state <= S_X2;
        S_X2: begin
          si    <= jb;
          state <= kind_up ? S_SUA : S_SDA;
        end
        S_FIN: state <= S_OUT;
        S_OUT: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- src/double_ended_priority_queue_unit.sv -----
// Top level of the double-ended priority queue: sequencer and two heap memories.
// Depends on depq_pkg, depq_mem and depq_seq.
//
// A word is taken when start is high and busy is low; busy then stays high until
// the result word, marked by done, has been on the result ports for one cycle, and
// the receiver must take it then. Replace and delete each run up to three sifts,
// and their pace is set by the single read port of each heap memory: every compare
// needs its operands read one at a time. Build runs a sift-down from every inner
// slot of both heaps.
module double_ended_priority_queue_unit import depq_pkg::*; #(
  parameter int CAPACITY = DEFAULT_CAPACITY,
  parameter int KEY_BITS = DEFAULT_KEY_BITS,
  parameter int CW       = $clog2(CAPACITY + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  logic [2:0]    mode,
  input  logic [31:0]   key,
  input  logic [7:0]    tag,
  output logic          done,
  output logic [31:0]   min_key,
  output logic [7:0]    min_tag,
  output logic [31:0]   max_key,
  output logic [7:0]    max_tag,
  output logic [CW-1:0] count,
  output logic [2:0]    status
);

  localparam int IW = $clog2(CAPACITY);

  mem_wr_t             m0_wr, m1_wr;
  logic [IW-1:0]       m0_wr_addr, m1_wr_addr, m0_wr_link, m1_wr_link, rd_addr;
  logic [KEY_BITS-1:0] m0_wr_key, m1_wr_key, m0_rd_key, m1_rd_key;
  logic [7:0]          m0_wr_tag, m1_wr_tag, m0_rd_tag, m1_rd_tag;
  logic [IW-1:0]       m0_rd_link, m1_rd_link;

  depq_seq #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS), .IW(IW), .CW(CW)) u_seq (
    .clk, .rst, .start, .busy, .mode, .key, .tag, .done,
    .min_key, .min_tag, .max_key, .max_tag, .count, .status,
    .m0_wr, .m0_wr_addr, .m0_wr_key, .m0_wr_tag, .m0_wr_link,
    .m1_wr, .m1_wr_addr, .m1_wr_key, .m1_wr_tag, .m1_wr_link,
    .rd_addr,
    .m0_rd_key, .m0_rd_tag, .m0_rd_link,
    .m1_rd_key, .m1_rd_tag, .m1_rd_link
  );

  // min heap
  depq_mem #(.KEY_BITS(KEY_BITS), .IW(IW)) u_min_mem (
    .clk, .wr(m0_wr), .wr_addr(m0_wr_addr), .wr_key(m0_wr_key), .wr_tag(m0_wr_tag),
    .wr_link(m0_wr_link), .rd_addr,
    .rd_key(m0_rd_key), .rd_tag(m0_rd_tag), .rd_link(m0_rd_link)
  );

  // max heap
  depq_mem #(.KEY_BITS(KEY_BITS), .IW(IW)) u_max_mem (
    .clk, .wr(m1_wr), .wr_addr(m1_wr_addr), .wr_key(m1_wr_key), .wr_tag(m1_wr_tag),
    .wr_link(m1_wr_link), .rd_addr,
    .rd_key(m1_rd_key), .rd_tag(m1_rd_tag), .rd_link(m1_rd_link)
  );

endmodule

// ----- test/double_ended_priority_queue_unit_test.sv -----
// Testbench for double_ended_priority_queue_unit: directed and random words checked
// against an in-bench twin-heap predictor. Depends on depq_pkg and the unit's RTL.
`timescale 1ns / 100ps

module double_ended_priority_queue_unit_test;
  import depq_pkg::*;

  localparam int CAP = 256;
  localparam logic [2:0] MODE_ILLEGAL = 3'd7;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [31:0] mn_key;
    logic [7:0]  mn_tag;
    logic [31:0] mx_key;
    logic [7:0]  mx_tag;
    logic [8:0]  cnt;
    logic [2:0]  st;
  } queue_report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [2:0]  mode = '0;
  logic [31:0] key = '0;
  logic [7:0]  tag = '0;
  logic        busy, done;
  logic [31:0] min_key, max_key;
  logic [7:0]  min_tag, max_tag;
  logic [8:0]  count;
  logic [2:0]  status;

  double_ended_priority_queue_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode), .key(key), .tag(tag),
    .done(done), .min_key(min_key), .min_tag(min_tag), .max_key(max_key),
    .max_tag(max_tag), .count(count), .status(status)
  );

  always #5 clk = ~clk;

  // predictor state: heap 0 is the min-heap, heap 1 the max-heap;
  // pos[h][i] is the slot of the same entry in the other heap
  logic [31:0] hkey[2][CAP];
  logic [7:0]  htag[2][CAP];
  int          pos[2][CAP];
  int          held;
  bit          built;

  queue_report_t reports_due[$];
  int errors = 0;
  int stall_cycles = 0;

  function automatic bit ranks_above(int h, int a, int b);
    if (hkey[h][a] != hkey[h][b])
      return h ? (hkey[h][a] > hkey[h][b]) : (hkey[h][a] < hkey[h][b]);
    return htag[h][a] < htag[h][b];
  endfunction

  function automatic void swap_slots(int h, int a, int b);
    logic [31:0] k;
    logic [7:0]  t;
    int          p;
    k = hkey[h][a]; hkey[h][a] = hkey[h][b]; hkey[h][b] = k;
    t = htag[h][a]; htag[h][a] = htag[h][b]; htag[h][b] = t;
    p = pos[h][a];  pos[h][a] = pos[h][b];   pos[h][b] = p;
    pos[1-h][pos[h][a]] = a;
    pos[1-h][pos[h][b]] = b;
  endfunction

  function automatic void sift_down(int h, int i, int n);
    int best, l, r;
    while (i < n) begin
      best = i; l = 2*i + 1; r = 2*i + 2;
      if (l < n && ranks_above(h, l, best)) best = l;
      if (r < n && ranks_above(h, r, best)) best = r;
      if (best == i) break;
      swap_slots(h, i, best);
      i = best;
    end
  endfunction

  function automatic void sift_up(int h, int i);
    int p;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (!ranks_above(h, i, p)) break;
      swap_slots(h, i, p);
      i = p;
    end
  endfunction

  function automatic void remove_slot(int h, int i, int n);
    int last;
    last = n - 1;
    if (i != last) begin
      hkey[h][i] = hkey[h][last];
      htag[h][i] = htag[h][last];
      pos[h][i] = pos[h][last];
      pos[1-h][pos[h][i]] = i;
    end
    if (i < last) begin
      sift_down(h, i, last);
      sift_up(h, i);
    end
  endfunction

  function automatic void predict_word(logic [2:0] m, logic [31:0] k, logic [7:0] t);
    queue_report_t r;
    int n, own, p;
    n = held;
    r = '0;
    r.st = STAT_OK;
    if (m == MODE_LOAD) begin
      if (n >= CAP) r.st = STAT_FULL;
      else begin
        for (int h = 0; h < 2; h++) begin
          hkey[h][n] = k; htag[h][n] = t; pos[h][n] = n;
        end
        held = n + 1;
        built = 0;
      end
    end else if (m == MODE_BUILD) begin
      for (int h = 0; h < 2; h++)
        for (int i = n/2 - 1; i >= 0; i--) sift_down(h, i, n);
      built = 1;
    end else if (m == MODE_ILLEGAL) r.st = STAT_BAD;
    else if (n == 0) r.st = STAT_EMPTY;
    else if (!built) r.st = STAT_NOTB;
    else if (m == MODE_RMIN || m == MODE_RMAX) begin
      own = (m == MODE_RMAX);
      p = pos[own][0];
      hkey[own][0] = k;
      hkey[1-own][p] = k;
      sift_down(own, 0, n);
      sift_down(1-own, p, n);
      sift_up(1-own, p);
    end else if (m == MODE_DMIN || m == MODE_DMAX) begin
      own = (m == MODE_DMAX);
      p = pos[own][0];
      remove_slot(own, 0, n);
      remove_slot(1-own, p, n);
      held = n - 1;
    end
    if (built && held > 0) begin
      r.mn_key = hkey[0][0]; r.mn_tag = htag[0][0];
      r.mx_key = hkey[1][0]; r.mx_tag = htag[1][0];
    end
    r.cnt = 9'(held);
    reports_due.push_back(r);
  endfunction

  // sender: called at a rising edge, returns at the edge that took the word
  task automatic send_word(logic [2:0] m, logic [31:0] k, logic [7:0] t);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1; mode <= m; key <= k; tag <= t;
    forever begin
      @(negedge clk);
      if (!busy) break;
    end
    @(posedge clk);
    predict_word(m, k, t);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2, 3, 4: return $urandom_range(0, 7);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] pick_tag();
    return ($urandom_range(0, 1)) ? 8'($urandom_range(0, 3)) : 8'($urandom);
  endfunction

  // result checker; outputs sampled mid-cycle, away from the driving edge
  always @(negedge clk) begin
    queue_report_t exp_r;
    if (!rst && done) begin
      if (reports_due.size() == 0) begin
        $display("%0t: result word with none expected, actual count %0d status %0d",
                 $time, count, status);
        errors++;
      end else begin
        exp_r = reports_due.pop_front();
        if (min_key !== exp_r.mn_key || min_tag !== exp_r.mn_tag ||
            max_key !== exp_r.mx_key || max_tag !== exp_r.mx_tag ||
            count !== exp_r.cnt || status !== exp_r.st) begin
          $display("%0t: mismatch expected min %h/%h max %h/%h cnt %0d st %0d", $time,
                   exp_r.mn_key, exp_r.mn_tag, exp_r.mx_key, exp_r.mx_tag, exp_r.cnt,
                   exp_r.st);
          $display("%0t:          actual   min %h/%h max %h/%h cnt %0d st %0d", $time,
                   min_key, min_tag, max_key, max_tag, count, status);
          errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst || done || (start && !busy)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic test_empty_and_status();
    send_word(MODE_PEEK, 0, 0);
    send_word(MODE_DMIN, 0, 0);
    send_word(MODE_ILLEGAL, 32'hFFFF_FFFF, 8'hFF);
    send_word(MODE_BUILD, 0, 0);
    send_word(MODE_DMAX, 0, 0);
    send_word(MODE_LOAD, 32'd0, 8'd0);
    send_word(MODE_LOAD, 32'hFFFF_FFFF, 8'hFF);
    send_word(MODE_PEEK, 0, 0);
    send_word(MODE_RMIN, 5, 0);
  endtask

  task automatic test_ties_and_ops();
    send_word(MODE_LOAD, 32'd7, 8'd9);
    send_word(MODE_LOAD, 32'd7, 8'd3);
    send_word(MODE_LOAD, 32'hFFFF_FFFF, 8'd1);
    send_word(MODE_LOAD, 32'd0, 8'd200);
    send_word(MODE_BUILD, 0, 0);
    send_word(MODE_PEEK, 0, 0);
    send_word(MODE_RMIN, 32'hFFFF_FFFF, 0);
    send_word(MODE_RMAX, 32'd0, 0);
    send_word(MODE_DMIN, 0, 0);
    send_word(MODE_DMAX, 0, 0);
    send_word(MODE_ILLEGAL, 0, 0);
    while (held > 0) send_word(MODE_DMIN, 0, 0);
    send_word(MODE_PEEK, 0, 0);
    drain();
  endtask

  task automatic test_full_queue();
    while (held < CAP) send_word(MODE_LOAD, pick_key(), pick_tag());
    send_word(MODE_LOAD, 1, 1);
    send_word(MODE_BUILD, 0, 0);
    repeat (30) send_word(3'($urandom_range(2, 6)), pick_key(), 0);
    while (held > 0) send_word($urandom_range(0, 1) ? MODE_DMIN : MODE_DMAX, 0, 0);
    drain();
  endtask

  task automatic test_random_sessions(int words);
    int sent, loads, ops;
    logic [2:0] m;
    sent = 0;
    while (sent < words) begin
      loads = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 12);
      for (int i = 0; i < loads && held < 200; i++) begin
        send_word(MODE_LOAD, pick_key(), pick_tag()); sent++;
      end
      send_word(MODE_BUILD, 0, 0); sent++;
      ops = $urandom_range(4, 30);
      for (int i = 0; i < ops; i++) begin
        case ($urandom_range(0, 19))
          0: m = MODE_LOAD;
          1: m = MODE_ILLEGAL;
          2: m = MODE_BUILD;
          default: m = 3'($urandom_range(2, 6));
        endcase
        send_word(m, pick_key(), pick_tag()); sent++;
      end
      if ($urandom_range(0, 7) == 0) drain();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_and_status();
    test_ties_and_ops();
    test_full_queue();
    test_random_sessions(710);
    drain();
    repeat (40) @(posedge clk);
    if (errors == 0 && reports_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
